// ----- hdl/pid_pkg.sv -----
package pid_pkg;

    // Shared multiplier geometry: 64-bit magnitudes, one 16-bit digit per cycle
    localparam int MUL_W     = 64;
    localparam int DIG_W     = 16;
    localparam int MUL_STEPS = MUL_W / DIG_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PART_W    = MUL_W + DIG_W;

    // Integral accumulator is a signed Q32.32-style 64-bit word
    localparam int LONG_W = 64;
    localparam logic [LONG_W-1:0] LONG_MAX = {1'b0, {(LONG_W-1){1'b1}}};
    localparam logic [LONG_W-1:0] LONG_MIN = {1'b1, {(LONG_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] REG_OUT_MAX = 3'd0;
    localparam logic [CFG_W-1:0] REG_OUT_MIN = 3'd1;
    localparam logic [CFG_W-1:0] REG_GAIN_P  = 3'd2;
    localparam logic [CFG_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CFG_W-1:0] REG_GAIN_I  = 3'd4;

    // Which product the shared multiplier works on
    typedef enum logic [1:0] {
        OP_P,
        OP_E,
        OP_I,
        OP_D
    } t_mul_op;

    // Arithmetic right shift applied to a product
    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_DFRAC
    } t_shift;

    typedef struct packed {
        logic    load_in;
        logic    mul_start;
        t_mul_op mul_op;
        logic    div_start;
        logic    mul_cap;
        logic    sum_pi;
        logic    sum_d;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_reset;
        logic dt_zero;
        logic mul_busy;
        logic div_busy;
    } t_dp_stat;

endpackage

// ----- hdl/pid_regulator.sv -----
// Discrete PID regulator in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits,
// Q16.16 by default). Each calculate beat forms error = target - measured (saturated),
// adds error * time_step into a saturating 64-bit integral, takes the derivative as
// (error - previous error) / time_step, sums the Kp, Ki and Kd terms with saturation,
// clamps the sum to [output_min, output_max] (upper limit tested first) and raises
// clamped when a limit was applied. A zero time step raises zero_step_error, zeroes the
// derivative term and adds nothing to the integral. A reset beat clears the integral and
// previous error and returns an all-zero result. Exactly one result beat per input beat.
// Timing: one item at a time. A calculate beat makes four passes (three with a zero
// time step) through one shared 64 x 16-bit multiplier, each a digit per cycle plus a
// round and a saturate step; the radix-4 divider runs beside the first multiplies and
// gates the derivative pass. A stall on the output side holds the block. The result
// sits in an output register, so the next beat is taken while it still waits.
// Configuration writes go to a plain write port (index 0..4: output_max, output_min,
// gain_p, gain_d, gain_i) and must be made only while the block is idle; the block
// itself does not enforce this.
module pid_regulator
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_index,
    input  logic [DATA_WIDTH-1:0]         i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [DATA_WIDTH-1:0]         i_time_step,
    input  logic signed [DATA_WIDTH-1:0]  i_target,
    input  logic signed [DATA_WIDTH-1:0]  i_measured,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [DATA_WIDTH-1:0]  o_drive,
    output logic                          o_clamped,
    output logic                          o_zero_step_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: walks the multiply passes, waits on the divider, owns the handshakes.
    pid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: registers, loop state, shared multiplier, divider, clamp.
    pid_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_time_step       (i_time_step),
        .i_target          (i_target),
        .i_measured        (i_measured),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_drive           (o_drive),
        .o_clamped         (o_clamped),
        .o_zero_step_error (o_zero_step_error)
    );

endmodule

// ----- hdl/pid_mul.sv -----
module pid_mul
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    input  t_shift                   i_shift,
    input  logic                     i_sat_long,
    output logic                     o_busy,
    output logic signed [MUL_W-1:0]  o_result
);

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_ACC,
        MS_RND,
        MS_SAT
    } t_ms;

    t_ms               r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [MUL_W-1:0]  r_ua, n_ua;
    logic [MUL_W-1:0]  r_ub, n_ub;
    logic              r_neg, n_neg;
    t_shift            r_shift, n_shift;
    logic              r_long, n_long;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [MUL_W-1:0]  r_res, n_res;

    logic [PART_W-1:0] part;
    logic [PART_W-1:0] hi_sum;
    logic [PROD_W-1:0] mask;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] q_hi;
    logic [MUL_W-1:0]  lim_hi;

    always_comb begin
        part   = {{(PART_W-MUL_W){1'b0}}, r_ua} * {{(PART_W-DIG_W){1'b0}}, r_ub[DIG_W-1:0]};
        hi_sum = {{(PART_W-MUL_W){1'b0}}, r_acc[PROD_W-1:MUL_W]} + part;

        case (r_shift)
            SH_NONE:  mask = '0;
            SH_FRAC:  mask = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
            SH_DFRAC: mask = (PROD_W'(1) << (2 * FRAC_BITS)) - PROD_W'(1);
            default:  mask = '0;
        endcase

        case (r_shift)
            SH_NONE:  q = r_acc;
            SH_FRAC:  q = r_acc >> FRAC_BITS;
            SH_DFRAC: q = r_acc >> (2 * FRAC_BITS);
            default:  q = r_acc;
        endcase

        // A magnitude at or past 2^lim saturates; the negative edge value equals the limit.
        if (r_long) begin
            q_hi   = q >> (LONG_W - 1);
            lim_hi = LONG_MAX;
        end else begin
            q_hi   = q >> (DATA_WIDTH - 1);
            lim_hi = (MUL_W'(1) << (DATA_WIDTH - 1)) - MUL_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_neg   = r_neg;
        n_shift = r_shift;
        n_long  = r_long;
        n_acc   = r_acc;
        n_res   = r_res;
        case (r_state)
            MS_IDLE: begin
                if (i_start) begin
                    n_ua    = i_a[MUL_W-1] ? MUL_W'(-i_a) : MUL_W'(i_a);
                    n_ub    = i_b[MUL_W-1] ? MUL_W'(-i_b) : MUL_W'(i_b);
                    n_neg   = i_a[MUL_W-1] ^ i_b[MUL_W-1];
                    n_shift = i_shift;
                    n_long  = i_sat_long;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = MS_ACC;
                end
            end
            MS_ACC: begin
                // Add one digit's partial product at the top, shift the sum down.
                n_acc = {hi_sum, r_acc[MUL_W-1:DIG_W]};
                n_ub  = r_ub >> DIG_W;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = MS_RND;
                end
            end
            MS_RND: begin
                // Round the magnitude up so the shift floors a negative product.
                if (r_neg) begin
                    n_acc = r_acc + mask;
                end
                n_state = MS_SAT;
            end
            MS_SAT: begin
                if (q_hi != '0) begin
                    n_res = r_neg ? ~lim_hi : lim_hi;
                end else begin
                    n_res = r_neg ? (MUL_W'(0) - q[MUL_W-1:0]) : q[MUL_W-1:0];
                end
                n_state = MS_IDLE;
            end
            default: begin
                n_state = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt   <= n_cnt;
        r_ua    <= n_ua;
        r_ub    <= n_ub;
        r_neg   <= n_neg;
        r_shift <= n_shift;
        r_long  <= n_long;
        r_acc   <= n_acc;
        r_res   <= n_res;
    end

    assign o_busy   = (r_state != MS_IDLE);
    assign o_result = r_res;

endmodule

// ----- hdl/pid_div.sv -----
module pid_div
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DATA_WIDTH:0]           i_num,
    input  logic                          i_neg,
    input  logic [DATA_WIDTH-1:0]         i_den,
    output logic                          o_busy,
    output logic signed [DATA_WIDTH-1:0]  o_quot
);

    localparam int NUM_W = DATA_WIDTH + 1;
    localparam int RAW_W = NUM_W + FRAC_BITS;
    localparam int STEPS = (RAW_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS);

    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_SAT
    } t_ds;

    t_ds                   r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [PAD_W-1:0]      r_dvd, n_dvd;
    logic [PAD_W-1:0]      r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_den, n_den;
    logic                  r_neg, n_neg;
    logic [DATA_WIDTH-1:0] r_res, n_res;

    logic [DATA_WIDTH:0]   t1, t2;
    logic                  ge1, ge2;
    logic [DATA_WIDTH-1:0] rem1, rem2;
    logic                  over;

    // Two restoring steps per cycle.
    always_comb begin
        t1   = {r_rem, r_dvd[PAD_W-1]};
        ge1  = (t1 >= {1'b0, r_den});
        rem1 = ge1 ? DATA_WIDTH'(t1 - {1'b0, r_den}) : t1[DATA_WIDTH-1:0];
        t2   = {rem1, r_dvd[PAD_W-2]};
        ge2  = (t2 >= {1'b0, r_den});
        rem2 = ge2 ? DATA_WIDTH'(t2 - {1'b0, r_den}) : t2[DATA_WIDTH-1:0];
        over = (r_quo[PAD_W-1:DATA_WIDTH-1] != '0);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        n_res   = r_res;
        case (r_state)
            DS_IDLE: begin
                if (i_start) begin
                    n_dvd   = PAD_W'({i_num, {FRAC_BITS{1'b0}}});
                    n_quo   = '0;
                    n_rem   = '0;
                    n_den   = i_den;
                    n_neg   = i_neg;
                    n_cnt   = CNT_W'(STEPS - 1);
                    n_state = DS_RUN;
                end
            end
            DS_RUN: begin
                n_rem = rem2;
                n_quo = {r_quo[PAD_W-3:0], ge1, ge2};
                n_dvd = r_dvd << 2;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = DS_SAT;
                end
            end
            DS_SAT: begin
                if (over) begin
                    n_res = r_neg ? DMIN : DMAX;
                end else begin
                    n_res = r_neg ? (DATA_WIDTH'(0) - r_quo[DATA_WIDTH-1:0])
                                  : r_quo[DATA_WIDTH-1:0];
                end
                n_state = DS_IDLE;
            end
            default: begin
                n_state = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_busy = (r_state != DS_IDLE);
    assign o_quot = r_res;

endmodule

// ----- hdl/pid_dp.sv -----
module pid_dp
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_index,
    input  logic [DATA_WIDTH-1:0]         i_cfg_data,
    input  logic                          i_command,
    input  logic [DATA_WIDTH-1:0]         i_time_step,
    input  logic signed [DATA_WIDTH-1:0]  i_target,
    input  logic signed [DATA_WIDTH-1:0]  i_measured,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    output logic signed [DATA_WIDTH-1:0]  o_drive,
    output logic                          o_clamped,
    output logic                          o_zero_step_error
);

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] sat_w(input logic [DW:0] v);
        logic [DW-1:0] s;
        if (v[DW] != v[DW-1]) begin
            s = v[DW] ? DMIN : DMAX;
        end else begin
            s = v[DW-1:0];
        end
        return s;
    endfunction

    function automatic logic [MUL_W-1:0] sx(input logic [DW-1:0] v);
        return {{(MUL_W-DW){v[DW-1]}}, v};
    endfunction

    // configuration
    logic [DW-1:0] r_out_max, r_out_min, r_gain_p, r_gain_d, r_gain_i;
    // loop state
    logic [DW-1:0]     r_prev;
    logic [LONG_W-1:0] r_int;
    // working registers
    logic          r_cmd;
    logic [DW-1:0] r_dt, r_tgt, r_meas;
    logic [DW-1:0] r_i_err;
    logic [DW-1:0] r_p, r_i, r_d, r_sum;
    logic [DW-1:0] r_drive;
    logic          r_clamped, r_zero_err;

    logic [DW:0]          err_diff;
    logic [DW-1:0]        err;
    logic [DW:0]          dd;
    logic [DW:0]          dd_mag;
    logic [MUL_W-1:0]     mul_a, mul_b, mul_res;
    t_shift               mul_shift;
    logic                 mul_long;
    logic                 mul_busy, div_busy;
    logic [DW-1:0]        deriv;
    logic [LONG_W:0]      int_sum;
    logic [LONG_W-1:0]    int_next;
    logic [DW-1:0]        d_use;
    logic                 dt_zero;

    assign dt_zero  = (r_dt == '0);
    assign err_diff = {r_tgt[DW-1], r_tgt} - {r_meas[DW-1], r_meas};
    assign err      = sat_w(err_diff);

    assign dd     = {r_i_err[DW-1], r_i_err} - {r_prev[DW-1], r_prev};
    assign dd_mag = dd[DW] ? (DW+1)'(-dd) : dd;

    always_comb begin
        mul_a     = sx(r_gain_p);
        mul_b     = sx(r_i_err);
        mul_shift = SH_FRAC;
        mul_long  = 1'b0;
        case (i_cmd.mul_op)
            OP_P: begin
                mul_a     = sx(r_gain_p);
                mul_b     = sx(r_i_err);
                mul_shift = SH_FRAC;
            end
            OP_E: begin
                mul_a     = sx(r_i_err);
                mul_b     = {{(MUL_W-DW){1'b0}}, r_dt};
                mul_shift = SH_NONE;
                mul_long  = 1'b1;
            end
            OP_I: begin
                mul_a     = sx(r_gain_i);
                mul_b     = r_int;
                mul_shift = SH_DFRAC;
            end
            OP_D: begin
                mul_a     = sx(r_gain_d);
                mul_b     = sx(deriv);
                mul_shift = SH_FRAC;
            end
            default: begin
                mul_a = sx(r_gain_p);
            end
        endcase
    end

    pid_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul_start),
        .i_a        (mul_a),
        .i_b        (mul_b),
        .i_shift    (mul_shift),
        .i_sat_long (mul_long),
        .o_busy     (mul_busy),
        .o_result   (mul_res)
    );

    pid_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (dd_mag),
        .i_neg   (dd[DW]),
        .i_den   (r_dt),
        .o_busy  (div_busy),
        .o_quot  (deriv)
    );

    // Saturating accumulate of error * dt.
    always_comb begin
        int_sum = {r_int[LONG_W-1], r_int} + {mul_res[LONG_W-1], mul_res};
        if (int_sum[LONG_W] != int_sum[LONG_W-1]) begin
            int_next = int_sum[LONG_W] ? LONG_MIN : LONG_MAX;
        end else begin
            int_next = int_sum[LONG_W-1:0];
        end
        d_use = dt_zero ? '0 : r_d;
    end

    // Configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_max <= DMAX;
            r_out_min <= DMIN;
            r_gain_p  <= '0;
            r_gain_d  <= '0;
            r_gain_i  <= '0;
            r_prev    <= '0;
            r_int     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OUT_MAX: r_out_max <= i_cfg_data;
                    REG_OUT_MIN: r_out_min <= i_cfg_data;
                    REG_GAIN_P:  r_gain_p  <= i_cfg_data;
                    REG_GAIN_D:  r_gain_d  <= i_cfg_data;
                    REG_GAIN_I:  r_gain_i  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mul_cap && (i_cmd.mul_op == OP_E)) begin
                r_int <= int_next;
            end
            if (i_cmd.load_out) begin
                if (r_cmd) begin
                    r_prev <= '0;
                    r_int  <= '0;
                end else begin
                    r_prev <= r_i_err;
                end
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_command;
            r_dt   <= i_time_step;
            r_tgt  <= i_target;
            r_meas <= i_measured;
        end
        r_i_err <= err;
        if (i_cmd.mul_cap) begin
            case (i_cmd.mul_op)
                OP_P:    r_p <= mul_res[DW-1:0];
                OP_I:    r_i <= mul_res[DW-1:0];
                OP_D:    r_d <= mul_res[DW-1:0];
                default: begin
                end
            endcase
        end
        if (i_cmd.sum_pi) begin
            r_sum <= sat_w({r_p[DW-1], r_p} + {r_i[DW-1], r_i});
        end
        if (i_cmd.sum_d) begin
            r_sum <= sat_w({r_sum[DW-1], r_sum} + {d_use[DW-1], d_use});
        end
        if (i_cmd.load_out) begin
            if (r_cmd) begin
                r_drive    <= '0;
                r_clamped  <= 1'b0;
                r_zero_err <= 1'b0;
            end else begin
                r_zero_err <= dt_zero;
                // Upper limit wins when the limits cross.
                if ($signed(r_sum) > $signed(r_out_max)) begin
                    r_drive   <= r_out_max;
                    r_clamped <= 1'b1;
                end else if ($signed(r_sum) < $signed(r_out_min)) begin
                    r_drive   <= r_out_min;
                    r_clamped <= 1'b1;
                end else begin
                    r_drive   <= r_sum;
                    r_clamped <= 1'b0;
                end
            end
        end
    end

    assign o_stat.cmd_reset = r_cmd;
    assign o_stat.dt_zero   = dt_zero;
    assign o_stat.mul_busy  = mul_busy;
    assign o_stat.div_busy  = div_busy;

    assign o_drive           = r_drive;
    assign o_clamped         = r_clamped;
    assign o_zero_step_error = r_zero_err;

endmodule

// ----- hdl/pid_ctrl.sv -----
module pid_ctrl
    import pid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_WAIT_P,
        ST_MUL_E,
        ST_WAIT_E,
        ST_MUL_I,
        ST_WAIT_I,
        ST_WAIT_DIV,
        ST_WAIT_D,
        ST_SUM_PI,
        ST_SUM_D,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_ERR;
                end
            end
            ST_ERR: begin
                // error register settles here; a reset item goes straight out
                n_state = i_stat.cmd_reset ? ST_OUT : ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = OP_P;
                o_cmd.div_start = !i_stat.dt_zero;
                n_state         = ST_WAIT_P;
            end
            ST_WAIT_P: begin
                o_cmd.mul_op = OP_P;
                if (!i_stat.mul_busy) begin
                    o_cmd.mul_cap = 1'b1;
                    n_state       = ST_MUL_E;
                end
            end
            ST_MUL_E: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = OP_E;
                n_state         = ST_WAIT_E;
            end
            ST_WAIT_E: begin
                o_cmd.mul_op = OP_E;
                if (!i_stat.mul_busy) begin
                    o_cmd.mul_cap = 1'b1;
                    n_state       = ST_MUL_I;
                end
            end
            ST_MUL_I: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = OP_I;
                n_state         = ST_WAIT_I;
            end
            ST_WAIT_I: begin
                o_cmd.mul_op = OP_I;
                if (!i_stat.mul_busy) begin
                    o_cmd.mul_cap = 1'b1;
                    n_state       = i_stat.dt_zero ? ST_SUM_PI : ST_WAIT_DIV;
                end
            end
            ST_WAIT_DIV: begin
                o_cmd.mul_op = OP_D;
                if (!i_stat.div_busy) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = ST_WAIT_D;
                end
            end
            ST_WAIT_D: begin
                o_cmd.mul_op = OP_D;
                if (!i_stat.mul_busy) begin
                    o_cmd.mul_cap = 1'b1;
                    n_state       = ST_SUM_PI;
                end
            end
            ST_SUM_PI: begin
                o_cmd.sum_pi = 1'b1;
                n_state      = ST_SUM_D;
            end
            ST_SUM_D: begin
                o_cmd.sum_d = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import pid_pkg::*;

    localparam int DW           = 32;
    localparam int FB           = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_BEATS  = 105;

    // command codes carried by the input beat
    localparam logic CMD_CALC  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // handy Q16.16 levels
    localparam logic signed [DW-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [DW-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [DW-1:0] Q_HUNDRED = 32'sh0064_0000;
    localparam logic signed [DW-1:0] Q_TEN     = 32'sh000A_0000;

    typedef logic signed [127:0] t_wide;
    localparam t_wide WORD_HI = 128'sh7FFF_FFFF;
    localparam t_wide WORD_LO = -WORD_HI - 1;
    localparam t_wide ACC_HI  = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_wide ACC_LO  = -ACC_HI - 1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef struct {
        logic                 command;
        logic [DW-1:0]        time_step;
        logic signed [DW-1:0] target;
        logic signed [DW-1:0] measured;
    } t_pid_beat;

    typedef struct {
        logic signed [DW-1:0] drive;
        logic                 clamped;
        logic                 zero_step_error;
    } t_pid_result;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_we          = 1'b0;
    logic [CFG_W-1:0]     i_cfg_index       = REG_OUT_MAX;
    logic [DW-1:0]        i_cfg_data        = '0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_stall;
    logic                 i_command         = CMD_CALC;
    logic [DW-1:0]        i_time_step       = '0;
    logic signed [DW-1:0] i_target          = '0;
    logic signed [DW-1:0] i_measured        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall       = 1'b0;
    logic signed [DW-1:0] o_drive;
    logic                 o_clamped;
    logic                 o_zero_step_error;

    pid_regulator #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_time_step      (i_time_step),
        .i_target         (i_target),
        .i_measured       (i_measured),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive),
        .o_clamped        (o_clamped),
        .o_zero_step_error(o_zero_step_error)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Controller shadow: configuration and loop state as the block holds them
    // ------------------------------------------------------------------
    logic signed [DW-1:0] lim_max;
    logic signed [DW-1:0] lim_min;
    logic signed [DW-1:0] kp;
    logic signed [DW-1:0] kd;
    logic signed [DW-1:0] ki;
    logic signed [DW-1:0] prev_err;
    logic signed [63:0]   integ;

    t_pid_beat   beat_q[$];          // beats waiting to be offered
    t_pid_result drive_expect_q[$];  // predicted results, oldest first
    t_pid_beat   cur_beat;
    t_pid_result want;

    t_idle idle_mode   = IDLE_NONE;
    int    beats_sent  = 0;   // popped by the driver
    int    results_seen = 0;  // taken by the monitor
    int    mismatches  = 0;
    int    cycles      = 0;
    int    hold_asks   = 0;
    int    hold_seen   = 0;
    int    hold_left   = 0;

    function automatic t_wide sat_word(t_wide x);
        if (x > WORD_HI) return WORD_HI;
        if (x < WORD_LO) return WORD_LO;
        return x;
    endfunction

    // Work out one result and advance the loop state (integral, last error).
    function automatic t_pid_result regulate(t_pid_beat b);
        t_pid_result r;
        t_wide err, dt, pterm, iterm, dterm, acc, diff, quot, deriv, total;
        r.drive           = '0;
        r.clamped         = 1'b0;
        r.zero_step_error = 1'b0;
        if (b.command == CMD_CLEAR) begin
            integ    = '0;
            prev_err = '0;
            return r;
        end
        err   = sat_word(t_wide'(b.target) - t_wide'(b.measured));
        dt    = t_wide'(b.time_step);
        pterm = sat_word((t_wide'(kp) * err) >>> FB);
        // integral is an exact product added with 64-bit saturation
        acc = t_wide'(integ) + err * dt;
        if (acc > ACC_HI) acc = ACC_HI;
        else if (acc < ACC_LO) acc = ACC_LO;
        integ = acc[63:0];
        iterm = sat_word((t_wide'(ki) * acc) >>> (2 * FB));
        dterm = '0;
        if (b.time_step == '0) begin
            r.zero_step_error = 1'b1;
        end else begin
            // quotient truncates toward zero: divide magnitudes, restore sign
            diff  = err - t_wide'(prev_err);
            quot  = ((diff < 0 ? -diff : diff) <<< FB) / dt;
            deriv = sat_word(diff < 0 ? -quot : quot);
            dterm = sat_word((t_wide'(kd) * deriv) >>> FB);
        end
        total = sat_word(sat_word(pterm + iterm) + dterm);
        // upper limit wins when the limits cross
        if (total > t_wide'(lim_max)) begin
            r.drive   = lim_max;
            r.clamped = 1'b1;
        end else if (total < t_wide'(lim_min)) begin
            r.drive   = lim_min;
            r.clamped = 1'b1;
        end else begin
            r.drive = total[DW-1:0];
        end
        prev_err = err[DW-1:0];
        return r;
    endfunction

    // Decide whether a side sits out this cycle, per the current idling phase.
    function automatic bit idle_roll(bit sender);
        int pct;
        case (idle_mode)
            IDLE_SEND: pct = sender ? 60 : 0;
            IDLE_RECV: pct = sender ? 0 : 60;
            IDLE_BOTH: pct = 11;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold a beat until it is taken, then offer the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // beat taken at this edge: predict its result now, config is stable
            if (i_in_valid && !o_in_stall)
                drive_expect_q.push_back(regulate(cur_beat));
            if (!i_in_valid || !o_in_stall) begin
                if (beat_q.size() != 0 && !idle_roll(1'b1)) begin
                    cur_beat = beat_q.pop_front();
                    beats_sent++;
                    i_in_valid  <= 1'b1;
                    i_command   <= cur_beat.command;
                    i_time_step <= cur_beat.time_step;
                    i_target    <= cur_beat.target;
                    i_measured  <= cur_beat.measured;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random per phase, or a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_roll(1'b0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (drive_expect_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: drive=%0d clamped=%0b zero_step=%0b",
                             o_drive, o_clamped, o_zero_step_error);
                mismatches++;
            end else begin
                want = drive_expect_q.pop_front();
                if (o_drive !== want.drive || o_clamped !== want.clamped ||
                    o_zero_step_error !== want.zero_step_error) begin
                    if (mismatches < 10)
                        $display({"result mismatch: expected drive=%0d clamped=%0b ",
                                  "zero_step=%0b, got drive=%0d clamped=%0b zero_step=%0b"},
                                 want.drive, want.clamped, want.zero_step_error,
                                 o_drive, o_clamped, o_zero_step_error);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic apply_reg(logic [CFG_W-1:0] idx, logic signed [DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_OUT_MAX: lim_max = val;
            REG_OUT_MIN: lim_min = val;
            REG_GAIN_P:  kp      = val;
            REG_GAIN_D:  kd      = val;
            REG_GAIN_I:  ki      = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic signed [DW-1:0] hi, logic signed [DW-1:0] lo,
                             logic signed [DW-1:0] p, logic signed [DW-1:0] d,
                             logic signed [DW-1:0] i);
        apply_reg(REG_OUT_MAX, hi);
        apply_reg(REG_OUT_MIN, lo);
        apply_reg(REG_GAIN_P, p);
        apply_reg(REG_GAIN_D, d);
        apply_reg(REG_GAIN_I, i);
    endtask

    // Block until every queued beat went out and every result came back.
    task automatic wait_idle();
        while (beat_q.size() != 0 || beats_sent != results_seen)
            @(posedge i_clk);
    endtask

    task automatic push_calc(logic [DW-1:0] ts, logic signed [DW-1:0] tg,
                             logic signed [DW-1:0] ms);
        t_pid_beat b;
        b.command   = CMD_CALC;
        b.time_step = ts;
        b.target    = tg;
        b.measured  = ms;
        beat_q.push_back(b);
    endtask

    // Clear beat with junk in the fields it must ignore
    task automatic push_clear();
        t_pid_beat b;
        b.command   = CMD_CLEAR;
        b.time_step = $urandom();
        b.target    = $urandom();
        b.measured  = $urandom();
        beat_q.push_back(b);
    endtask

    function automatic logic signed [DW-1:0] rand_level();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_step();
        case ($urandom_range(11))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom();
            default: return $urandom_range(32'h0004_0000, 32'h0000_0100);
        endcase
    endfunction

    // kind: 0 tame, 1 wide random, 2 extremes
    function automatic logic signed [DW-1:0] rand_gain(int kind);
        if (kind == 0)
            return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        if (kind == 1)
            return $urandom();
        case ($urandom_range(3))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [DW-1:0] rand_limit(int kind);
        if (kind == 2)
            return $urandom_range(1) ? Q_MAX : Q_MIN;
        if (kind == 1 && $urandom_range(3) == 0)
            return $urandom();
        return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endfunction

    task automatic random_setup(int kind);
        logic signed [DW-1:0] a, b, t;
        a = rand_limit(kind);
        b = rand_limit(kind);
        // keep limits ordered most of the time, leave some crossed
        if (a < b && $urandom_range(4) != 0) begin
            t = a;
            a = b;
            b = t;
        end
        configure(a, b, rand_gain(kind), rand_gain(kind), rand_gain(kind));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        lim_max  = Q_MAX;
        lim_min  = Q_MIN;
        kp       = '0;
        kd       = '0;
        ki       = '0;
        prev_err = '0;
        integ    = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: gains zero, drive stays zero; zero step still flagged
        push_calc('0, Q_MAX, Q_MIN);
        push_calc(Q_ONE, Q_TEN, -Q_TEN);
        push_clear();
        wait_idle();

        // pure P at unity gain so drive equals error: probe the limit edges
        configure(Q_HUNDRED, -Q_HUNDRED, Q_ONE, '0, '0);
        push_calc('0, Q_HUNDRED, '0);
        push_calc('0, Q_HUNDRED + 1, '0);
        push_calc('0, '0, Q_HUNDRED);
        push_calc('0, '0, Q_HUNDRED + 1);
        wait_idle();

        // crossed limits: upper tested first, then lower
        configure(-Q_TEN, Q_TEN, Q_ONE, '0, '0);
        push_calc(Q_ONE, '0, '0);
        push_calc(Q_ONE, -Q_TEN, Q_TEN);
        wait_idle();

        // extreme gains: drive the integral into both rails, saturate the derivative
        configure(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        push_calc(32'hFFFF_FFFF, Q_MAX, Q_MIN);
        push_calc(32'hFFFF_FFFF, Q_MAX, Q_MIN);
        push_calc(32'hFFFF_FFFF, Q_MIN, Q_MAX);
        push_calc(32'hFFFF_FFFF, Q_MIN, Q_MAX);
        push_calc(32'h0000_0001, Q_MAX, Q_MIN);
        push_calc(32'h0000_0001, Q_MIN, Q_MAX);
        push_calc('0, Q_MAX, Q_MAX);
        push_clear();
        push_calc(32'h0000_0001, '0, 32'sh0000_0001);
        push_calc(Q_ONE, Q_ONE, '0);
        wait_idle();

        // random phases across idling patterns and configurations
        for (int ph = 0; ph < 8; ph++) begin
            random_setup(ph % 3);
            idle_mode = t_idle'(ph % 4);
            // one no-idle phase also gets the long output hold-off
            if (ph == 4)
                hold_asks <= hold_asks + 1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(11) == 0)
                    push_clear();
                else
                    push_calc(rand_step(), rand_level(), rand_level());
            end
            wait_idle();
        end

        // let anything stray surface before judging
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && drive_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
